[rtl/mhvd_pkg.sv]
// Package with shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps

package mhvd_pkg;

    localparam int DEPTH     = 128;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CHILD_W   = ADDR_W + 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Commands from the controller to the datapath, one per controller state.
    typedef struct packed {
        logic accept;
        logic disp;
        logic srch;
        logic del_rd;
        logic del_dec;
        logic up_rd;
        logic up_cmp;
        logic dn_rd;
        logic dn_cmp;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic full;
        logic empty;
        logic match;
        logic scan_end;
        logic found_last;
        logic go_up;
        logic at_root;
        logic no_child;
        logic move_up;
        logic move_down;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/min_heap_with_value_delete.sv]
// Top level of the min-heap priority queue with delete by key value.
//
// Input channel: i_valid, o_stall, i_command, i_key. An item is taken when
// i_valid is high and o_stall is low. Insert (0) adds i_key, delete (1)
// removes the first stored entry equal to i_key, query (2 or 3) only reports.
// Output channel: o_valid, i_stall, o_status, o_min_key, o_is_empty,
// o_entry_count. Every item yields exactly one result describing the heap
// after the command. A result register sits on the output, so a new item is
// taken while an earlier result still waits to be read.
// Items are handled one at a time. A query or a dropped insert goes from
// dispatch straight to the done state, where its result is registered.
// An insert climbs one level per read and compare step, at most 7 levels.
// A delete scans the heap one entry per cycle through one read port; a miss
// ends at the last held entry. After a match the last entry is fetched, moved
// into the hole and sifted up or down one level per read and compare step.
// Reset empties the heap; memory contents are not cleared. If the receiver
// stalls, the finished result holds and the block waits before finishing
// the following item.
`timescale 1ns / 1ps

module min_heap_with_value_delete
    import mhvd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic signed [KEY_WIDTH-1:0] o_min_key,
    output logic                        o_is_empty,
    output logic [CNT_W-1:0]            o_entry_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    idle;

    mhvd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_idle  (idle),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mhvd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_min_key     (o_min_key),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count)
    );

    assign o_stall = !idle;

endmodule

[rtl/mhvd_datapath.sv]
// Datapath: heap memory, index and key registers, compares and the result register.
`timescale 1ns / 1ps

module mhvd_datapath
    import mhvd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic [1:0]                  i_command,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic signed [KEY_WIDTH-1:0] o_min_key,
    output logic                        o_is_empty,
    output logic [CNT_W-1:0]            o_entry_count
);

    logic signed [KEY_WIDTH-1:0] r_mem [DEPTH];

    logic [1:0]                  r_cmd;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]            r_cnt;
    logic [ADDR_W-1:0]           r_idx;
    logic signed [KEY_WIDTH-1:0] r_cur;
    logic [ADDR_W-1:0]           r_scan;
    logic [ADDR_W-1:0]           r_sidx;
    logic                        r_spend;
    logic signed [KEY_WIDTH-1:0] r_root;
    logic [1:0]                  r_status;
    logic signed [KEY_WIDTH-1:0] r_rda;
    logic signed [KEY_WIDTH-1:0] r_rdb;

    logic                        r_o_valid;
    logic [1:0]                  r_o_status;
    logic signed [KEY_WIDTH-1:0] r_o_min;
    logic                        r_o_empty;
    logic [CNT_W-1:0]            r_o_cnt;

    logic [ADDR_W-1:0]           parent;
    logic [CHILD_W-1:0]          c1;
    logic [CHILD_W-1:0]          c2;
    logic                        pick_b;
    logic signed [KEY_WIDTH-1:0] pick_val;
    logic [ADDR_W-1:0]           pick_idx;
    logic [ADDR_W-1:0]           addr_a;
    logic [ADDR_W-1:0]           addr_b;
    logic                        wr_en;
    logic signed [KEY_WIDTH-1:0] wr_data;
    logic                        sidx_last;

    assign parent    = (r_idx - ADDR_W'(1)) >> 1;
    assign c1        = {1'b0, r_idx, 1'b1};
    assign c2        = c1 + CHILD_W'(1);
    assign pick_b    = (c2 < CHILD_W'(r_cnt)) && (r_rdb < r_rda);
    assign pick_val  = pick_b ? r_rdb : r_rda;
    assign pick_idx  = pick_b ? c2[ADDR_W-1:0] : c1[ADDR_W-1:0];
    assign sidx_last = (CNT_W'(r_sidx) + CNT_W'(1)) == r_cnt;

    always_comb begin
        o_sts.is_insert  = (r_cmd == CMD_INSERT);
        o_sts.is_delete  = (r_cmd == CMD_DELETE);
        o_sts.full       = (r_cnt == DEPTH_CNT);
        o_sts.empty      = (r_cnt == '0);
        o_sts.match      = r_spend && (r_rda == r_key);
        o_sts.scan_end   = r_spend && (r_rda != r_key) && sidx_last;
        o_sts.found_last = sidx_last;
        o_sts.go_up      = (r_idx != '0) && (r_rda < r_rdb);
        o_sts.at_root    = (r_idx == '0);
        o_sts.no_child   = (c1 >= CHILD_W'(r_cnt));
        o_sts.move_up    = (r_cur < r_rdb);
        o_sts.move_down  = (r_cur > pick_val);
        o_sts.out_free   = !r_o_valid || !i_stall;
    end

    // Read addresses for the two read ports.
    always_comb begin
        addr_a = r_scan;
        addr_b = parent;
        if (i_cmd.del_rd) begin
            addr_a = r_cnt[ADDR_W-1:0];
        end else if (i_cmd.dn_rd) begin
            addr_a = c1[ADDR_W-1:0];
            addr_b = c2[ADDR_W-1:0];
        end
    end

    // The moving key travels as a hole; every write lands at the current index.
    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_cur;
        if (i_cmd.up_rd && o_sts.at_root) begin
            wr_en = 1'b1;
        end else if (i_cmd.up_cmp) begin
            wr_en   = 1'b1;
            wr_data = o_sts.move_up ? r_rdb : r_cur;
        end else if (i_cmd.del_dec && o_sts.go_up) begin
            wr_en   = 1'b1;
            wr_data = r_rdb;
        end else if (i_cmd.dn_rd && o_sts.no_child) begin
            wr_en = 1'b1;
        end else if (i_cmd.dn_cmp) begin
            wr_en   = 1'b1;
            wr_data = o_sts.move_down ? pick_val : r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        r_rda <= r_mem[addr_a];
        r_rdb <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.disp && o_sts.is_insert && !o_sts.full) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.srch && o_sts.match) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.finish && o_sts.out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
        end
        if (wr_en && r_idx == '0) begin
            r_root <= wr_data;
        end
        if (i_cmd.disp) begin
            r_status <= ST_OK;
            r_scan   <= '0;
            r_spend  <= 1'b0;
            if (o_sts.is_insert) begin
                if (o_sts.full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_idx <= r_cnt[ADDR_W-1:0];
                    r_cur <= r_key;
                end
            end else if (o_sts.is_delete && o_sts.empty) begin
                r_status <= ST_NOTFOUND;
            end
        end
        if (i_cmd.srch) begin
            r_scan  <= r_scan + ADDR_W'(1);
            r_sidx  <= r_scan;
            r_spend <= 1'b1;
            if (o_sts.match) begin
                r_idx <= r_sidx;
            end else if (o_sts.scan_end) begin
                r_status <= ST_NOTFOUND;
            end
        end
        if (i_cmd.del_dec) begin
            r_cur <= r_rda;
            if (o_sts.go_up) begin
                r_idx <= parent;
            end
        end
        if (i_cmd.up_cmp && o_sts.move_up) begin
            r_idx <= parent;
        end
        if (i_cmd.dn_cmp && o_sts.move_down) begin
            r_idx <= pick_idx;
        end
        if (i_cmd.finish && o_sts.out_free) begin
            r_o_status <= r_status;
            r_o_min    <= (r_cnt == '0) ? '0 : r_root;
            r_o_empty  <= (r_cnt == '0);
            r_o_cnt    <= r_cnt;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_min_key     = r_o_min;
    assign o_is_empty    = r_o_empty;
    assign o_entry_count = r_o_cnt;

endmodule

[rtl/mhvd_ctrl.sv]
// Controller state machine that sequences insert, search, delete and sift steps.
`timescale 1ns / 1ps

module mhvd_ctrl
    import mhvd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_idle,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DISP    = 10'b00_0000_0010,
        S_SRCH    = 10'b00_0000_0100,
        S_DEL_RD  = 10'b00_0000_1000,
        S_DEL_DEC = 10'b00_0001_0000,
        S_UP_RD   = 10'b00_0010_0000,
        S_UP_CMP  = 10'b00_0100_0000,
        S_DN_RD   = 10'b00_1000_0000,
        S_DN_CMP  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.is_insert && !i_sts.full) begin
                    n_state = S_UP_RD;
                end else if (i_sts.is_delete && !i_sts.empty) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                if (i_sts.match) begin
                    n_state = i_sts.found_last ? S_DONE : S_DEL_RD;
                end else if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DEL_RD: begin
                n_state = S_DEL_DEC;
            end
            S_DEL_DEC: begin
                n_state = i_sts.go_up ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD: begin
                n_state = i_sts.at_root ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = i_sts.move_up ? S_UP_RD : S_DONE;
            end
            S_DN_RD: begin
                n_state = i_sts.no_child ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP: begin
                n_state = i_sts.move_down ? S_DN_RD : S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_cmd.accept  = (r_state == S_IDLE) && i_valid;
        o_cmd.disp    = (r_state == S_DISP);
        o_cmd.srch    = (r_state == S_SRCH);
        o_cmd.del_rd  = (r_state == S_DEL_RD);
        o_cmd.del_dec = (r_state == S_DEL_DEC);
        o_cmd.up_rd   = (r_state == S_UP_RD);
        o_cmd.up_cmp  = (r_state == S_UP_CMP);
        o_cmd.dn_rd   = (r_state == S_DN_RD);
        o_cmd.dn_cmp  = (r_state == S_DN_CMP);
        o_cmd.finish  = (r_state == S_DONE);
    end

endmodule

[rtl/mhvd_checker.sv]
// Port-level checker for the heap block and its bind to the top level.
`timescale 1ns / 1ps

module mhvd_checker
    import mhvd_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [1:0]                  o_status,
    input logic signed [KEY_WIDTH-1:0] o_min_key,
    input logic                        o_is_empty,
    input logic [CNT_W-1:0]            o_entry_count
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= DEPTH_CNT))
        else $error("entry count above heap depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_min_key == '0))
        else $error("minimum not zero on an empty heap");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_FULL ||
                     o_status == ST_NOTFOUND))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_entry_count) &&
                                  $stable(o_min_key)))
        else $error("stalled result changed");

endmodule

bind min_heap_with_value_delete mhvd_checker u_mhvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_min_key     (o_min_key),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count)
);
